// ----- sv/mtrc_pkg.sv -----
// shared types, codes and constants of the modbus tcp response checker
`default_nettype none

package mtrc_pkg;

    localparam int HeaderLen   = 6;
    localparam int CheckLen    = 0;
    localparam int ExcFrameLen = HeaderLen + 3 + CheckLen;

    localparam int AddrW      = 3;
    localparam int DataW      = 32;
    localparam int LimitReset = 12;

    localparam logic [7:0] FnExcFlag = 8'h80;

    localparam logic [7:0] FnReadCoils      = 8'd1;
    localparam logic [7:0] FnReadInputs     = 8'd2;
    localparam logic [7:0] FnReadHolding    = 8'd3;
    localparam logic [7:0] FnReadInputRegs  = 8'd4;
    localparam logic [7:0] FnReadExcStatus  = 8'd7;
    localparam logic [7:0] FnWriteCoils     = 8'd15;
    localparam logic [7:0] FnWriteRegs      = 8'd16;
    localparam logic [7:0] FnReportSlaveId  = 8'd17;

    localparam logic [1:0] StatusGood    = 2'd0;
    localparam logic [1:0] StatusTimeout = 2'd1;

    localparam logic [0:0] RegExcLimit = 1'b0;

    typedef enum logic [2:0] {
        V_OK            = 3'd0,
        V_MISMATCH      = 3'd1,
        V_TIMEOUT       = 3'd2,
        V_EXCEPTION     = 3'd3,
        V_BAD_EXCEPTION = 3'd4,
        V_PASSED        = 3'd5
    } t_verdict;

    typedef struct packed {
        logic [1:0]  receive_status;
        logic [7:0]  query_function;
        logic [15:0] query_quantity;
        logic [7:0]  reply_function;
        logic [7:0]  reply_byte_count;
        logic [15:0] reply_quantity;
        logic [8:0]  received_length;
    } t_item;

    typedef struct packed {
        t_verdict    verdict;
        logic [15:0] value_count;
        logic [7:0]  exception_value;
        logic [17:0] expected_length;
    } t_result;

endpackage

`default_nettype wire

// ----- sv/mtrc_regs.sv -----
// apb configuration register holding the exception code limit
`default_nettype none

module mtrc_regs (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [mtrc_pkg::AddrW-1:0] paddr,
    input  wire logic [mtrc_pkg::DataW-1:0] pwdata,
    output logic      [mtrc_pkg::DataW-1:0] prdata,
    output logic                            pready,
    output logic      [7:0]                 o_exc_limit
);
    import mtrc_pkg::*;

    logic [7:0] r_limit;
    logic [7:0] n_limit;
    logic       sel_limit;

    assign sel_limit = (paddr[AddrW-1] == RegExcLimit);

    always_comb begin
        n_limit = r_limit;
        if (psel && penable && pwrite && sel_limit) begin
            n_limit = pwdata[7:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= 8'(LimitReset);
        end else begin
            r_limit <= n_limit;
        end
    end

    assign pready      = 1'b1;
    assign prdata      = sel_limit ? {{(DataW-8){1'b0}}, r_limit} : '0;
    assign o_exc_limit = r_limit;

endmodule

`default_nettype wire

// ----- sv/mtrc_eval.sv -----
// length and verdict evaluation of one query and response word
`default_nettype none

module mtrc_eval (
    input  wire mtrc_pkg::t_item   i_item,
    input  wire logic [7:0]        i_exc_limit,
    output mtrc_pkg::t_result      o_res
);
    import mtrc_pkg::*;

    logic [13:0] bit_bytes;
    logic [17:0] body_len;
    logic [8:0]  exc_fn;
    logic        exc_frame;
    logic [15:0] want;
    logic [15:0] got;

    assign bit_bytes = {1'b0, i_item.query_quantity[15:3]} + 14'(|i_item.query_quantity[2:0]);

    always_comb begin
        unique case (i_item.query_function)
            FnReadCoils, FnReadInputs:
                body_len = 18'd3 + 18'(bit_bytes);
            FnReadHolding, FnReadInputRegs:
                body_len = 18'd3 + {1'b0, i_item.query_quantity, 1'b0};
            FnReadExcStatus:
                body_len = 18'd4;
            default:
                body_len = 18'd6;
        endcase
    end

    always_comb begin
        unique case (i_item.reply_function)
            FnReadCoils, FnReadInputs: begin
                want = 16'(bit_bytes);
                got  = {8'd0, i_item.reply_byte_count};
            end
            FnReadHolding, FnReadInputRegs: begin
                want = i_item.query_quantity;
                got  = {9'd0, i_item.reply_byte_count[7:1]};
            end
            FnWriteCoils, FnWriteRegs: begin
                want = i_item.query_quantity;
                got  = i_item.reply_quantity;
            end
            FnReportSlaveId: begin
                want = {7'd0, i_item.received_length};
                got  = {7'd0, i_item.received_length};
            end
            default: begin
                want = 16'd1;
                got  = 16'd1;
            end
        endcase
    end

    assign exc_fn    = {1'b0, i_item.query_function} + {1'b0, FnExcFlag};
    assign exc_frame = (i_item.received_length == 9'(ExcFrameLen))
                    && (exc_fn == {1'b0, i_item.reply_function});

    always_comb begin
        o_res.value_count     = 16'd0;
        o_res.exception_value = 8'd0;
        o_res.expected_length = body_len + 18'(HeaderLen + CheckLen);
        priority if (i_item.receive_status == StatusGood) begin
            if (want == got) begin
                o_res.verdict     = V_OK;
                o_res.value_count = got;
            end else begin
                o_res.verdict = V_MISMATCH;
            end
        end else if (i_item.receive_status == StatusTimeout) begin
            o_res.verdict = V_TIMEOUT;
            if (exc_frame) begin
                o_res.exception_value = i_item.reply_byte_count;
                o_res.verdict = (i_item.reply_byte_count < i_exc_limit)
                              ? V_EXCEPTION : V_BAD_EXCEPTION;
            end
        end else begin
            o_res.verdict = V_PASSED;
        end
    end

endmodule

`default_nettype wire

// ----- sv/modbus_tcp_response_checker.sv -----
// path: input register, combinational evaluation, result register driving the outputs
// throughput: one word per cycle if i_out_ready holds; both registers hand on every cycle
// the two stages stall together only when both hold a word and the result is not taken
// reset: synchronous active low, clears both stage valids and sets the limit to 12
// top level of the modbus tcp response checker
`default_nettype none

module modbus_tcp_response_checker (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [mtrc_pkg::AddrW-1:0] paddr,
    input  wire logic [mtrc_pkg::DataW-1:0] pwdata,
    output logic      [mtrc_pkg::DataW-1:0] prdata,
    output logic                            pready,
    input  wire logic                       i_in_valid,
    output logic                            o_in_ready,
    input  wire logic [1:0]                 i_receive_status,
    input  wire logic [7:0]                 i_query_function,
    input  wire logic [15:0]                i_query_quantity,
    input  wire logic [7:0]                 i_reply_function,
    input  wire logic [7:0]                 i_reply_byte_count,
    input  wire logic [15:0]                i_reply_quantity,
    input  wire logic [8:0]                 i_received_length,
    output logic                            o_out_valid,
    input  wire logic                       i_out_ready,
    output logic      [2:0]                 o_verdict,
    output logic      [15:0]                o_value_count,
    output logic      [7:0]                 o_exception_value,
    output logic      [17:0]                o_expected_length
);
    import mtrc_pkg::*;

    logic       [7:0] exc_limit;
    t_item            r_item;
    t_item            n_item;
    logic             r_s1_valid;
    t_result          res;
    t_result          r_res;
    logic             r_s2_valid;
    logic             s1_ready;
    logic             s2_ready;
    logic             in_fire;
    logic             s1_move;

    mtrc_regs u_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .o_exc_limit (exc_limit)
    );

    mtrc_eval u_eval (
        .i_item      (r_item),
        .i_exc_limit (exc_limit),
        .o_res       (res)
    );

    assign s2_ready   = !r_s2_valid || i_out_ready;
    assign s1_ready   = !r_s1_valid || s2_ready;
    assign in_fire    = i_in_valid && s1_ready;
    assign s1_move    = r_s1_valid && s2_ready;
    assign o_in_ready = s1_ready;

    always_comb begin
        n_item.receive_status   = i_receive_status;
        n_item.query_function   = i_query_function;
        n_item.query_quantity   = i_query_quantity;
        n_item.reply_function   = i_reply_function;
        n_item.reply_byte_count = i_reply_byte_count;
        n_item.reply_quantity   = i_reply_quantity;
        n_item.received_length  = i_received_length;
    end

    // input word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_ready) begin
            r_s1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_item <= n_item;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (s2_ready) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r_res <= res;
        end
    end

    assign o_out_valid       = r_s2_valid;
    assign o_verdict         = r_res.verdict;
    assign o_value_count     = r_res.value_count;
    assign o_exception_value = r_res.exception_value;
    assign o_expected_length = r_res.expected_length;

    a_limit_reset: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> (exc_limit == 8'(LimitReset)))
        else $error("exception limit not restored by reset");

    a_fire_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> r_s1_valid)
        else $error("accepted word lost in input register");

    a_count_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (r_res.verdict != V_OK)) |-> (o_value_count == 16'd0))
        else $error("value count set on a failed verdict");

    a_exc_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (r_res.verdict != V_EXCEPTION)
            && (r_res.verdict != V_BAD_EXCEPTION)) |-> (o_exception_value == 8'd0))
        else $error("exception value set without an exception");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !s2_ready) |=> (r_s1_valid && $stable(r_item)))
        else $error("input register changed while the result stalled");

endmodule

`default_nettype wire
